// ===== sv/slot_id_allocator_core_macros.svh =====
// assertion helpers for the slot allocator
`ifndef SLOT_ID_ALLOCATOR_CORE_MACROS_SVH
`define SLOT_ID_ALLOCATOR_CORE_MACROS_SVH

// same-cycle implication
`define SIA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SIA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/sia_pkg.sv =====
`default_nettype none
package sia_pkg;

  localparam int SLOTS  = 32;
  localparam int SLOT_W = 5;
  localparam int CNT_W  = 6;
  localparam int HND_W  = 32;

  // operation codes
  typedef enum logic [2:0] {
    MODE_ADD_DYN = 3'd0,
    MODE_ADD_FIX = 3'd1,
    MODE_REMOVE  = 3'd2,
    MODE_GET     = 3'd3,
    MODE_FIRST   = 3'd4,
    MODE_NEXT    = 3'd5,
    MODE_CLEAR   = 3'd6
  } mode_t;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_FULL       = 3'd1,
    ST_HAS_ID     = 3'd2,
    ST_RANGE      = 3'd3,
    ST_FIX_TAKEN  = 3'd4,
    ST_NO_ID      = 3'd5,
    ST_NOT_FOUND  = 3'd6,
    ST_CONFLICT   = 3'd7
  } status_t;

  // controller states
  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_DYN_PUT, S_REMOVE, S_RD_OUT, S_SEARCH, S_CLR_SCAN,
    S_CLR_DONE, S_FIX_DEST, S_MOVE, S_DROP_SCAN, S_DROP_RD, S_DROP_WR,
    S_FIX_PUT, S_PUSH, S_DONE
  } state_t;

  // datapath micro-operations
  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_CHECK, OP_DYN_PUT, OP_REMOVE, OP_RD_OUT, OP_SEARCH,
    OP_CLR_SCAN, OP_CLR_DONE, OP_FIX_DEST, OP_MOVE, OP_DROP_SCAN, OP_DROP_WR,
    OP_FIX_PUT, OP_PUSH, OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       chk_ok;
    logic       slot_used;
    logic       slot_instk;
    logic       live_nz;
    logic       idx_zero;
    logic       fix_conflict;
    logic       scan_end;
    logic       scan_hit;
    logic       scan_last;
    logic       drop_hit;
    logic       push_last;
    logic       out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== sv/sia_ram.sv =====
`default_nettype none
module sia_ram #(
  parameter int W = 32,
  parameter int D = 32
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic [$clog2(D)-1:0] raddr,
  output logic      [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== sv/sia_ctrl.sv =====
`default_nettype none
module sia_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire sia_pkg::dp_stat_t stat,
  output sia_pkg::dp_cmd_t       cmd
);
  import sia_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        if (!stat.chk_ok) begin
          state_nxt = S_DONE;
        end else begin
          case (stat.mode)
            MODE_ADD_DYN: state_nxt = S_DYN_PUT;
            MODE_ADD_FIX: begin
              if (stat.slot_used) state_nxt = S_FIX_DEST;
              else if (stat.slot_instk) state_nxt = S_DROP_SCAN;
              else state_nxt = S_FIX_PUT;
            end
            MODE_REMOVE: state_nxt = S_REMOVE;
            MODE_GET:    state_nxt = S_RD_OUT;
            MODE_FIRST, MODE_NEXT: state_nxt = S_SEARCH;
            MODE_CLEAR:  state_nxt = stat.live_nz ? S_CLR_SCAN : S_CLR_DONE;
            default:     state_nxt = S_DONE;
          endcase
        end
      end
      S_DYN_PUT, S_REMOVE, S_RD_OUT, S_CLR_DONE: state_nxt = S_DONE;
      S_SEARCH: begin
        if (stat.scan_end) state_nxt = S_DONE;
        else if (stat.scan_hit) state_nxt = S_RD_OUT;
      end
      S_CLR_SCAN: begin
        if (stat.scan_last) state_nxt = S_CLR_DONE;
      end
      S_FIX_DEST: state_nxt = stat.fix_conflict ? S_DONE : S_MOVE;
      S_MOVE:     state_nxt = S_FIX_PUT;
      S_DROP_SCAN: begin
        if (stat.drop_hit) state_nxt = S_DROP_RD;
      end
      S_DROP_RD:  state_nxt = S_DROP_WR;
      S_DROP_WR:  state_nxt = S_FIX_PUT;
      S_FIX_PUT:  state_nxt = stat.idx_zero ? S_DONE : S_PUSH;
      S_PUSH: begin
        if (stat.push_last) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    in_tready = 1'b0;
    cmd.op    = OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) cmd.op = OP_LOAD;
      end
      S_DECODE:    cmd.op = OP_CHECK;
      S_DYN_PUT:   cmd.op = OP_DYN_PUT;
      S_REMOVE:    cmd.op = OP_REMOVE;
      S_RD_OUT:    cmd.op = OP_RD_OUT;
      S_SEARCH:    cmd.op = OP_SEARCH;
      S_CLR_SCAN:  cmd.op = OP_CLR_SCAN;
      S_CLR_DONE:  cmd.op = OP_CLR_DONE;
      S_FIX_DEST:  cmd.op = OP_FIX_DEST;
      S_MOVE:      cmd.op = OP_MOVE;
      S_DROP_SCAN: cmd.op = OP_DROP_SCAN;
      S_DROP_RD:   cmd.op = OP_NONE;
      S_DROP_WR:   cmd.op = OP_DROP_WR;
      S_FIX_PUT:   cmd.op = OP_FIX_PUT;
      S_PUSH:      cmd.op = OP_PUSH;
      S_DONE:      cmd.op = stat.out_free ? OP_EMIT : OP_NONE;
      default:     cmd.op = OP_NONE;
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/sia_dp.sv =====
`default_nettype none
module sia_dp (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire sia_pkg::dp_cmd_t      cmd,
  output sia_pkg::dp_stat_t          stat,
  input  wire logic [2:0]            in_mode,
  input  wire logic [31:0]           in_handle,
  input  wire logic signed [5:0]     in_slot,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [2:0]                 out_status,
  output logic [4:0]                 out_slot,
  output logic [31:0]                out_handle,
  output logic                       out_moved,
  output logic [31:0]                out_moved_handle,
  output logic [4:0]                 out_moved_slot,
  output logic [5:0]                 out_live
);
  import sia_pkg::*;

  // captured beat
  logic [2:0]        mode_r;
  logic [HND_W-1:0]  handle_r;
  logic [5:0]        slot_r;

  // table state
  logic [SLOTS-1:0]  used_r, fixed_r, instk_r;
  logic [CNT_W-1:0]  depth_r, live_r;
  logic [SLOT_W-1:0] cursor_r;
  logic [7:0]        wcount_r;

  // sequencing registers
  logic [CNT_W-1:0]  scan_r;
  logic [SLOT_W-1:0] pos_r, chk_slot_r, dest_r;
  logic              chk_v_r;

  // result registers
  logic [2:0]        st_r;
  logic [SLOT_W-1:0] so_r, ms_r;
  logic [HND_W-1:0]  ho_r, mh_r;
  logic              mv_r;

  // memories
  logic              h_we, s_we;
  logic [SLOT_W-1:0] h_waddr, h_raddr, s_waddr, s_raddr, s_wdata;
  logic [HND_W-1:0]  h_wdata, h_rdata;
  logic [SLOT_W-1:0] s_rdata;

  logic [SLOT_W-1:0] idx, scan_i, dyn_idx;
  logic              no_id, neg;
  logic [2:0]        chk;
  logic [CNT_W-1:0]  dest6, depth_m1;
  logic              push_ok;

  assign idx      = slot_r[SLOT_W-1:0];
  assign scan_i   = scan_r[SLOT_W-1:0];
  assign no_id    = (slot_r == 6'h3f);
  assign neg      = slot_r[5];
  assign depth_m1 = depth_r - CNT_W'(1);
  assign dyn_idx  = (depth_r != '0) ? s_rdata : live_r[SLOT_W-1:0];
  assign dest6    = (depth_r != '0) ? {1'b0, s_rdata} : live_r - CNT_W'(1);
  assign push_ok  = (scan_r < {1'b0, idx}) && !used_r[scan_i] && !instk_r[scan_i] &&
                    (depth_r < CNT_W'(SLOTS));

  // early checks per operation
  always_comb begin
    chk = ST_OK;
    case (mode_r)
      MODE_ADD_DYN: begin
        if (live_r >= CNT_W'(SLOTS)) chk = ST_FULL;
        else if (!no_id) chk = ST_HAS_ID;
      end
      MODE_ADD_FIX: begin
        if (no_id) chk = ST_NO_ID;
        else if (neg) chk = ST_RANGE;
        else if (used_r[idx] && fixed_r[idx]) chk = ST_FIX_TAKEN;
      end
      MODE_REMOVE, MODE_GET: begin
        if (no_id) chk = ST_NO_ID;
        else if (neg) chk = ST_RANGE;
        else if (!used_r[idx]) chk = ST_NOT_FOUND;
      end
      MODE_FIRST: begin
        if (live_r == '0) chk = ST_NOT_FOUND;
      end
      MODE_NEXT: begin
        if (wcount_r == {2'b00, live_r}) chk = ST_NOT_FOUND;
      end
      MODE_CLEAR: chk = ST_OK;
      default:    chk = ST_RANGE;
    endcase
  end

  // status toward the controller
  always_comb begin
    stat.mode         = mode_r;
    stat.chk_ok       = (chk == ST_OK);
    stat.slot_used    = used_r[idx];
    stat.slot_instk   = instk_r[idx];
    stat.live_nz      = (live_r != '0);
    stat.idx_zero     = (idx == '0);
    stat.fix_conflict = dest6[5] || (dest6[SLOT_W-1:0] == idx) || used_r[dest6[SLOT_W-1:0]];
    stat.scan_end     = scan_r[5];
    stat.scan_hit     = !scan_r[5] && used_r[scan_i];
    stat.scan_last    = (scan_i == SLOT_W'(SLOTS - 1));
    stat.drop_hit     = chk_v_r && (s_rdata == idx);
    stat.push_last    = (scan_r + CNT_W'(1) == {1'b0, idx});
    stat.out_free     = !out_valid || out_ready;
  end

  // memory port selection
  always_comb begin
    h_raddr = (cmd.op == OP_SEARCH) ? scan_i : idx;
    h_we    = 1'b0;
    h_waddr = idx;
    h_wdata = handle_r;
    s_raddr = (cmd.op == OP_DROP_SCAN) ? scan_i : depth_m1[SLOT_W-1:0];
    s_we    = 1'b0;
    s_waddr = depth_r[SLOT_W-1:0];
    s_wdata = idx;
    case (cmd.op)
      OP_DYN_PUT: begin
        h_we    = 1'b1;
        h_waddr = dyn_idx;
      end
      OP_MOVE: begin
        h_we    = 1'b1;
        h_waddr = dest_r;
        h_wdata = h_rdata;
      end
      OP_FIX_PUT: h_we = 1'b1;
      OP_REMOVE:  s_we = (depth_r < CNT_W'(SLOTS));
      OP_DROP_WR: begin
        s_we    = 1'b1;
        s_waddr = pos_r;
        s_wdata = s_rdata;
      end
      OP_PUSH: begin
        s_we    = push_ok;
        s_wdata = scan_i;
      end
      default: ;
    endcase
  end

  sia_ram #(.W(HND_W), .D(SLOTS)) u_handle_ram (
    .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
    .raddr(h_raddr), .rdata(h_rdata)
  );

  sia_ram #(.W(SLOT_W), .D(SLOTS)) u_stack_ram (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  // table control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r   <= '0;
      fixed_r  <= '0;
      instk_r  <= '0;
      depth_r  <= '0;
      live_r   <= '0;
      cursor_r <= '0;
      wcount_r <= '0;
      chk_v_r  <= 1'b0;
    end else begin
      case (cmd.op)
        OP_CHECK: chk_v_r <= 1'b0;
        OP_DYN_PUT: begin
          used_r[dyn_idx]  <= 1'b1;
          fixed_r[dyn_idx] <= 1'b0;
          live_r           <= live_r + CNT_W'(1);
          if (depth_r != '0) begin
            depth_r          <= depth_m1;
            instk_r[dyn_idx] <= 1'b0;
          end
        end
        OP_REMOVE: begin
          if (depth_r < CNT_W'(SLOTS)) begin
            depth_r      <= depth_r + CNT_W'(1);
            instk_r[idx] <= 1'b1;
          end
          used_r[idx]  <= 1'b0;
          fixed_r[idx] <= 1'b0;
          if (live_r != '0) live_r <= live_r - CNT_W'(1);
          wcount_r <= wcount_r - 8'd1;
        end
        OP_SEARCH: begin
          if (!scan_r[5] && used_r[scan_i]) begin
            cursor_r <= scan_i;
            wcount_r <= (mode_r == MODE_FIRST) ? 8'd1 : wcount_r + 8'd1;
          end
        end
        OP_CLR_SCAN: begin
          if (used_r[scan_i]) cursor_r <= scan_i;
        end
        OP_CLR_DONE: begin
          if (live_r != '0) wcount_r <= {2'b00, live_r};
          used_r  <= '0;
          fixed_r <= '0;
          instk_r <= '0;
          depth_r <= '0;
          live_r  <= '0;
        end
        OP_FIX_DEST: begin
          if (!(dest6[5] || (dest6[SLOT_W-1:0] == idx) || used_r[dest6[SLOT_W-1:0]])) begin
            if (depth_r != '0) begin
              depth_r                      <= depth_m1;
              instk_r[dest6[SLOT_W-1:0]]   <= 1'b0;
            end
          end
        end
        OP_MOVE: begin
          used_r[dest_r]  <= 1'b1;
          fixed_r[dest_r] <= 1'b0;
        end
        OP_DROP_SCAN: chk_v_r <= (scan_r < depth_r);
        OP_DROP_WR: begin
          depth_r      <= depth_m1;
          instk_r[idx] <= 1'b0;
        end
        OP_FIX_PUT: begin
          used_r[idx]  <= 1'b1;
          fixed_r[idx] <= 1'b1;
          if (!mv_r) live_r <= live_r + CNT_W'(1);
        end
        OP_PUSH: begin
          if (push_ok) begin
            depth_r         <= depth_r + CNT_W'(1);
            instk_r[scan_i] <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // beat capture, scan counter and result fields
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        mode_r   <= in_mode;
        handle_r <= in_handle;
        slot_r   <= in_slot;
        st_r     <= ST_OK;
        so_r     <= '0;
        ho_r     <= '0;
        mv_r     <= 1'b0;
        mh_r     <= '0;
        ms_r     <= '0;
      end
      OP_CHECK: begin
        st_r   <= chk;
        scan_r <= (mode_r == MODE_NEXT) ? {1'b0, cursor_r} + CNT_W'(1) : '0;
        if (mode_r == MODE_GET && chk == ST_OK) so_r <= idx;
      end
      OP_DYN_PUT: so_r <= dyn_idx;
      OP_REMOVE:  so_r <= idx;
      OP_RD_OUT:  ho_r <= h_rdata;
      OP_SEARCH: begin
        if (scan_r[5]) st_r <= ST_NOT_FOUND;
        else if (used_r[scan_i]) so_r <= scan_i;
        else scan_r <= scan_r + CNT_W'(1);
      end
      OP_CLR_SCAN:  scan_r <= scan_r + CNT_W'(1);
      OP_FIX_DEST: begin
        dest_r <= dest6[SLOT_W-1:0];
        if (dest6[5] || (dest6[SLOT_W-1:0] == idx) || used_r[dest6[SLOT_W-1:0]]) begin
          st_r <= ST_CONFLICT;
        end
      end
      OP_MOVE: begin
        mv_r <= 1'b1;
        mh_r <= h_rdata;
        ms_r <= dest_r;
      end
      OP_DROP_SCAN: begin
        chk_slot_r <= scan_i;
        scan_r     <= scan_r + CNT_W'(1);
        if (chk_v_r && (s_rdata == idx)) pos_r <= chk_slot_r;
      end
      OP_FIX_PUT: begin
        so_r   <= idx;
        scan_r <= '0;
      end
      OP_PUSH: scan_r <= scan_r + CNT_W'(1);
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (cmd.op == OP_EMIT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_EMIT) begin
      out_status       <= st_r;
      out_slot         <= so_r;
      out_handle       <= ho_r;
      out_moved        <= mv_r;
      out_moved_handle <= mh_r;
      out_moved_slot   <= ms_r;
      out_live         <= live_r;
    end
  end

endmodule
`default_nettype wire

// ===== sv/slot_id_allocator_core.sv =====
`default_nettype none
// Slot id allocator for 32 slots. Each input beat carries one command (in_tuser)
// with a handle and a signed slot id; each command yields exactly one result
// beat with a status and the live count. Commands run one at a time: a beat is
// accepted, then worked through by a small sequencer that touches one table or
// free-stack entry per cycle through small RAMs with one write port and one
// registered read port. A rejected command goes straight to its result beat;
// dynamic add, remove and get need no scan; first and next scan the occupancy
// bits one slot per cycle; clear with a non-empty table scans all 32 slots; a
// fixed add may search the free stack and then scan the slots below the claimed
// one. A result that is still held in the output register delays the next one.
// The next beat is accepted as soon as the result has moved into the output
// register.
module slot_id_allocator_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // handle[31:0], slot[37:32], zero pad
  input  wire logic [2:0]  in_tuser,   // mode[2:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [87:0]      out_tdata,  // slot_out[4:0], handle_out[36:5], moved[37],
                                       // moved_handle[69:38], moved_slot[74:70],
                                       // live_count_out[80:75], zero pad
  output logic [2:0]       out_tuser   // status[2:0]
);
  import sia_pkg::*;

  dp_cmd_t     cmd;
  dp_stat_t    stat;
  logic [2:0]  o_status;
  logic [4:0]  o_slot, o_mslot;
  logic [31:0] o_handle, o_mhandle;
  logic        o_moved;
  logic [5:0]  o_live;

  sia_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .stat(stat), .cmd(cmd)
  );

  sia_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .in_mode(in_tuser), .in_handle(in_tdata[31:0]), .in_slot(in_tdata[37:32]),
    .out_valid(out_tvalid), .out_ready(out_tready),
    .out_status(o_status), .out_slot(o_slot), .out_handle(o_handle),
    .out_moved(o_moved), .out_moved_handle(o_mhandle), .out_moved_slot(o_mslot),
    .out_live(o_live)
  );

  // result beat packing
  assign out_tuser = o_status;
  assign out_tdata = {7'd0, o_live, o_mslot, o_mhandle, o_moved, o_handle, o_slot};

`include "slot_id_allocator_core_macros.svh"

  `SIA_ASSERT_NEXT(a_one_at_a_time, in_tvalid && in_tready, !in_tready, "beat accepted while busy")
  `SIA_ASSERT_NOW(a_live_bound, out_tvalid, out_tdata[80:75] <= 6'd32, "live count above table size")
  `SIA_ASSERT_NOW(a_move_only_ok, out_tvalid && out_tuser != ST_OK, !out_tdata[37], "move flagged on error")

endmodule
`default_nettype wire

// ===== tb/tb_slot_id_allocator_core.sv =====
`default_nettype none
module tb_slot_id_allocator_core;
  import sia_pkg::*;

  localparam logic [2:0] MODE_UNDEF = 3'd7;
  localparam int RAND_CMDS = 1250;
  localparam int CYCLE_LIMIT = 800000;
  localparam int DRAIN_CYCLES = 120;

  typedef struct {
    logic [2:0] mode;
    logic [31:0] handle;
    logic [5:0] slot;
  } cmd_t;

  typedef struct {
    status_t status;
    logic [4:0] slot_out;
    logic [31:0] handle_out;
    logic moved;
    logic [31:0] moved_handle;
    logic [4:0] moved_slot;
    logic [5:0] live;
  } res_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [39:0] in_tdata;
  logic [2:0] in_tuser;
  logic out_tvalid;
  logic out_tready;
  logic [87:0] out_tdata;
  logic [2:0] out_tuser;

  slot_id_allocator_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  // shadow of the slot table
  logic [31:0] tbl_handle [SLOTS];
  bit tbl_used [SLOTS];
  bit tbl_fixed [SLOTS];
  logic [4:0] free_ids [SLOTS];
  int free_cnt;
  int live_cnt;
  int walk_pos;
  logic [7:0] walk_seen;

  cmd_t pending_cmds [$];
  res_t expected_results [$];
  cmd_t cur_cmd;
  int cmds_total;
  int cmds_sent;
  int errors;
  int send_gap;
  int recv_stall;
  int cycles;

  function automatic bit id_is_free_listed(int s);
    for (int i = 0; i < free_cnt; i++) begin
      if (free_ids[i] == s) return 1;
    end
    return 0;
  endfunction

  function automatic void free_push(int s);
    if (free_cnt < SLOTS) begin
      free_ids[free_cnt] = s[4:0];
      free_cnt++;
    end
  endfunction

  function automatic void free_unlist(int s);
    int pos;
    pos = SLOTS;
    for (int i = 0; i < free_cnt; i++) begin
      if (free_ids[i] == s) pos = i;
    end
    if (pos == SLOTS || free_cnt == 0) return;
    free_cnt--;
    free_ids[pos] = free_ids[free_cnt];
  endfunction

  function automatic res_t r_finish(res_t r);
    res_t o;
    o = r;
    o.live = live_cnt[5:0];
    return o;
  endfunction

  // apply one command to the shadow table and return its result
  function automatic res_t allocate_step(cmd_t c);
    res_t r;
    int sid;
    int idx;
    int dest;
    bit ranged;
    int wc;
    r = '{ST_OK, 0, 0, 0, 0, 0, 0};
    sid = $signed(c.slot);
    ranged = sid >= 0 && sid < SLOTS;
    idx = ranged ? sid : 0;
    case (c.mode)
      MODE_ADD_DYN: begin
        if (live_cnt >= SLOTS) r.status = ST_FULL;
        else if (sid != -1) r.status = ST_HAS_ID;
        else begin
          if (free_cnt > 0) begin
            free_cnt--;
            idx = free_ids[free_cnt];
          end else idx = live_cnt;
          if (idx >= SLOTS) r.status = ST_FULL;
          else begin
            tbl_handle[idx] = c.handle;
            tbl_used[idx] = 1;
            tbl_fixed[idx] = 0;
            live_cnt++;
            r.slot_out = idx[4:0];
          end
        end
      end
      MODE_ADD_FIX: begin
        if (sid == -1) r.status = ST_NO_ID;
        else if (!ranged) r.status = ST_RANGE;
        else if (tbl_used[idx] && tbl_fixed[idx]) r.status = ST_FIX_TAKEN;
        else begin
          if (tbl_used[idx]) begin
            dest = (free_cnt > 0) ? free_ids[free_cnt - 1] : live_cnt - 1;
            if (dest < 0 || dest >= SLOTS || dest == idx || tbl_used[dest]) begin
              r.status = ST_CONFLICT;
              return r_finish(r);
            end
            if (free_cnt > 0) free_cnt--;
            tbl_handle[dest] = tbl_handle[idx];
            tbl_used[dest] = 1;
            tbl_fixed[dest] = 0;
            r.moved = 1;
            r.moved_handle = tbl_handle[idx];
            r.moved_slot = dest[4:0];
          end else begin
            free_unlist(idx);
            live_cnt++;
          end
          tbl_handle[idx] = c.handle;
          tbl_used[idx] = 1;
          tbl_fixed[idx] = 1;
          for (int i = 0; i < idx; i++) begin
            if (!tbl_used[i] && !id_is_free_listed(i)) free_push(i);
          end
          r.slot_out = idx[4:0];
        end
      end
      MODE_REMOVE: begin
        if (sid == -1) r.status = ST_NO_ID;
        else if (!ranged) r.status = ST_RANGE;
        else if (!tbl_used[idx]) r.status = ST_NOT_FOUND;
        else begin
          free_push(idx);
          tbl_used[idx] = 0;
          tbl_fixed[idx] = 0;
          if (live_cnt > 0) live_cnt--;
          walk_seen = walk_seen - 8'd1;
          r.slot_out = idx[4:0];
        end
      end
      MODE_GET: begin
        if (sid == -1) r.status = ST_NO_ID;
        else if (!ranged) r.status = ST_RANGE;
        else if (!tbl_used[idx]) r.status = ST_NOT_FOUND;
        else begin
          r.slot_out = idx[4:0];
          r.handle_out = tbl_handle[idx];
        end
      end
      MODE_FIRST: begin
        r.status = ST_NOT_FOUND;
        if (live_cnt != 0) begin
          for (int i = 0; i < SLOTS; i++) begin
            if (tbl_used[i]) begin
              walk_pos = i;
              walk_seen = 8'd1;
              r.status = ST_OK;
              r.slot_out = i[4:0];
              r.handle_out = tbl_handle[i];
              break;
            end
          end
        end
      end
      MODE_NEXT: begin
        wc = $signed(walk_seen);
        r.status = ST_NOT_FOUND;
        if (wc != live_cnt) begin
          for (int i = walk_pos + 1; i < SLOTS; i++) begin
            if (tbl_used[i]) begin
              walk_pos = i;
              walk_seen = walk_seen + 8'd1;
              r.status = ST_OK;
              r.slot_out = i[4:0];
              r.handle_out = tbl_handle[i];
              break;
            end
          end
        end
      end
      MODE_CLEAR: begin
        if (live_cnt > 0) begin
          for (int i = 0; i < SLOTS; i++) begin
            if (tbl_used[i]) walk_pos = i;
          end
          walk_seen = live_cnt[7:0];
        end
        for (int i = 0; i < SLOTS; i++) begin
          tbl_used[i] = 0;
          tbl_fixed[i] = 0;
        end
        free_cnt = 0;
        live_cnt = 0;
      end
      default: r.status = ST_RANGE;
    endcase
    return r_finish(r);
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  function automatic cmd_t mk(logic [2:0] m, logic [31:0] h, int s);
    cmd_t c;
    c.mode = m;
    c.handle = h;
    c.slot = s[5:0];
    return c;
  endfunction

  // draw one random command, mostly well-formed
  function automatic cmd_t rand_cmd();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 34) return mk(MODE_ADD_DYN, $urandom, -1);
    if (pick < 48) return mk(MODE_ADD_FIX, $urandom, $urandom_range(0, 31));
    if (pick < 68) return mk(MODE_REMOVE, $urandom, $urandom_range(0, 31));
    if (pick < 76) return mk(MODE_GET, $urandom, $urandom_range(0, 31));
    if (pick < 80) return mk(MODE_FIRST, $urandom, $urandom_range(0, 63));
    if (pick < 91) return mk(MODE_NEXT, $urandom, $urandom_range(0, 63));
    if (pick < 93) return mk(MODE_CLEAR, $urandom, $urandom_range(0, 63));
    if (pick < 94) return mk(MODE_UNDEF, $urandom, $urandom_range(0, 63));
    return mk(3'($urandom_range(0, 6)), $urandom, $urandom_range(0, 63));
  endfunction

  // clock
  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // command list and end of run
  initial begin
    rst_n = 0;
    errors = 0;
    pending_cmds.push_back(mk(MODE_FIRST, 32'h0, 0));
    pending_cmds.push_back(mk(MODE_NEXT, 32'h0, 0));
    pending_cmds.push_back(mk(MODE_ADD_DYN, 32'h0000_0000, -1));
    pending_cmds.push_back(mk(MODE_ADD_DYN, 32'hFFFF_FFFF, -1));
    pending_cmds.push_back(mk(MODE_ADD_DYN, 32'h1234_5678, 5));
    pending_cmds.push_back(mk(MODE_ADD_FIX, 32'hAAAA_5555, -1));
    pending_cmds.push_back(mk(MODE_ADD_FIX, 32'hAAAA_5555, -5));
    pending_cmds.push_back(mk(MODE_ADD_FIX, 32'h5555_AAAA, 1));
    pending_cmds.push_back(mk(MODE_ADD_FIX, 32'h5555_AAAA, 0));
    pending_cmds.push_back(mk(MODE_ADD_FIX, 32'hC0DE_0010, 10));
    pending_cmds.push_back(mk(MODE_ADD_FIX, 32'hC0DE_0011, 10));
    pending_cmds.push_back(mk(MODE_ADD_DYN, 32'hD00D_0009, -1));
    pending_cmds.push_back(mk(MODE_ADD_FIX, 32'hC0DE_0009, 9));
    pending_cmds.push_back(mk(MODE_REMOVE, 32'h0, -1));
    pending_cmds.push_back(mk(MODE_REMOVE, 32'h0, -32));
    pending_cmds.push_back(mk(MODE_REMOVE, 32'h0, 20));
    pending_cmds.push_back(mk(MODE_GET, 32'h0, -1));
    pending_cmds.push_back(mk(MODE_GET, 32'h0, 31));
    pending_cmds.push_back(mk(MODE_GET, 32'h0, 10));
    pending_cmds.push_back(mk(MODE_FIRST, 32'h0, 0));
    pending_cmds.push_back(mk(MODE_REMOVE, 32'h0, 0));
    pending_cmds.push_back(mk(MODE_NEXT, 32'h0, 0));
    pending_cmds.push_back(mk(MODE_CLEAR, 32'h0, 0));
    pending_cmds.push_back(mk(MODE_NEXT, 32'h0, 0));
    pending_cmds.push_back(mk(MODE_UNDEF, 32'hFFFF_FFFF, 31));
    for (int i = 0; i < RAND_CMDS; i++) pending_cmds.push_back(rand_cmd());
    cmds_total = pending_cmds.size();
    repeat (3) @(posedge clk);
    rst_n <= 1;
    wait (cmds_sent == cmds_total);
    wait (expected_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // command driver
  always @(posedge clk) begin
    bit fire;
    bit vld;
    if (!rst_n) begin
      in_tvalid <= 0;
      in_tdata <= '0;
      in_tuser <= '0;
      cmds_sent <= 0;
      send_gap = 0;
      free_cnt = 0;
      live_cnt = 0;
      walk_pos = 0;
      walk_seen = 8'd0;
      for (int i = 0; i < SLOTS; i++) begin
        tbl_used[i] = 0;
        tbl_fixed[i] = 0;
      end
    end else begin
      fire = in_tvalid && in_tready;
      if (fire) begin
        expected_results.push_back(allocate_step(cur_cmd));
        void'(pending_cmds.pop_front());
        cmds_sent <= cmds_sent + 1;
        // every third stretch of 100 beats runs without gaps
        send_gap = ((cmds_sent / 100) % 3 == 1) ? 0 : $urandom_range(0, 8);
      end
      if (!in_tvalid || fire) begin
        vld = 0;
        if (send_gap > 0) send_gap--;
        else if (pending_cmds.size() > 0) begin
          cur_cmd = pending_cmds[0];
          vld = 1;
        end
        in_tvalid <= vld;
        in_tdata <= {2'b00, cur_cmd.slot, cur_cmd.handle};
        in_tuser <= cur_cmd.mode;
      end
    end
  end

  // result monitor with random back-pressure
  always @(posedge clk) begin
    res_t want;
    bit rdy;
    if (!rst_n) begin
      out_tready <= 0;
      recv_stall = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          $error("result beat with no command outstanding");
          errors++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", want.status, out_tuser);
          check_field("slot_out", want.slot_out, out_tdata[4:0]);
          check_field("handle_out", want.handle_out, out_tdata[36:5]);
          check_field("moved", want.moved, out_tdata[37]);
          check_field("moved_handle", want.moved_handle, out_tdata[69:38]);
          check_field("moved_slot", want.moved_slot, out_tdata[74:70]);
          check_field("live_count_out", want.live, out_tdata[80:75]);
          check_field("pad", 32'h0, out_tdata[87:81]);
        end
        recv_stall = ((cmds_sent / 150) % 3 == 2) ? 0 : $urandom_range(0, 8);
      end
      rdy = 1;
      if (recv_stall > 0) begin
        recv_stall--;
        rdy = 0;
      end
      out_tready <= rdy;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= (rst_n) ? cycles + 1 : 0;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

endmodule
`default_nettype wire
